/* src/gsc_pkg.sv */
// shared types and constants for the gamepad stick conditioner
package gsc_pkg;

  localparam int AXIS_W = 8;
  localparam int OUT_W  = 16;
  localparam int BTN_W  = 16;
  localparam int CNT_W  = 5;

  // iteration counts of the shift-subtract unit, minus one
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd31;
  localparam logic [CNT_W-1:0] SQRT_LAST = 5'd15;

  // configuration register indexes
  localparam logic [1:0] CFG_DEAD_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_DEAD_OFFSET    = 2'd1;
  localparam logic [1:0] CFG_MAX_RADIUS     = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQR,
    ST_CMP,
    ST_MAG_INIT,
    ST_MAG_RUN,
    ST_STORE_U,
    ST_CLAMP_MAG,
    ST_AX_SQ,
    ST_AX_MUL,
    ST_AX_DIV_INIT,
    ST_AX_DIV,
    ST_AX_SQRT_INIT,
    ST_AX_SQRT,
    ST_AX_STORE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_XX,
    OP_MUL_YY,
    OP_MUL_RR,
    OP_MUL_AA,
    OP_MUL_AR,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT_S,
    OP_SQRT_INIT_Q,
    OP_SQRT_STEP,
    OP_STORE_AX,
    OP_STORE_UNCLAMP,
    OP_STORE_CLAMP_MAG
  } op_t;

  typedef struct packed {
    op_t  op;
    logic axis;   // 0 selects x, 1 selects y
  } ctl_t;

  typedef struct packed {
    logic [6:0] dead_threshold;
    logic [6:0] dead_offset;
    logic [7:0] max_radius;
  } cfg_t;

endpackage

/* src/gsc_datapath.sv */
// dead zone, shared multiplier and shared shift-subtract unit for divide and square root
module gsc_datapath (
  input  logic                                 clk,
  input  gsc_pkg::ctl_t                        ctl,
  input  gsc_pkg::cfg_t                        cfg,
  input  logic signed [gsc_pkg::AXIS_W-1:0]    raw_x,
  input  logic signed [gsc_pkg::AXIS_W-1:0]    raw_y,
  output logic                                 clamp,
  output logic signed [gsc_pkg::OUT_W-1:0]     axis_x,
  output logic signed [gsc_pkg::OUT_W-1:0]     axis_y,
  output logic        [gsc_pkg::OUT_W-1:0]     magnitude
);

  logic [7:0]  ax_r, ay_r;
  logic        sx_r, sy_r;
  logic [15:0] s_r, r2_r;
  logic [31:0] prod_r;
  logic [31:0] sh_r;
  logic [31:0] res_r;
  logic [18:0] rem_r;
  logic [15:0] ox_r, oy_r, mag_r;

  logic [7:0]  dz_x, dz_y;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [18:0] cand, trial, diff;
  logic        ge;
  logic [7:0]  a_sel;
  logic        s_sel;
  logic [15:0] q16, q16_signed;

  function automatic logic [7:0] dead_zone(input logic [7:0] raw,
                                           input logic [6:0] thr,
                                           input logic [6:0] off);
    logic [7:0] mag;
    logic [7:0] res;
    mag = raw[7] ? (8'd0 - raw) : raw;
    if (mag < {1'b0, thr}) begin
      res = 8'd0;
    end else if (mag > {1'b0, off}) begin
      res = mag - {1'b0, off};
    end else begin
      res = 8'd0;
    end
    return res;
  endfunction

  assign dz_x = dead_zone(raw_x, cfg.dead_threshold, cfg.dead_offset);
  assign dz_y = dead_zone(raw_y, cfg.dead_threshold, cfg.dead_offset);

  assign a_sel = ctl.axis ? ay_r : ax_r;
  assign s_sel = ctl.axis ? sy_r : sx_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.op)
      gsc_pkg::OP_MUL_XX: begin
        mul_a = {8'd0, ax_r};
        mul_b = {8'd0, ax_r};
      end
      gsc_pkg::OP_MUL_YY: begin
        mul_a = {8'd0, ay_r};
        mul_b = {8'd0, ay_r};
      end
      gsc_pkg::OP_MUL_RR: begin
        mul_a = {8'd0, cfg.max_radius};
        mul_b = {8'd0, cfg.max_radius};
      end
      gsc_pkg::OP_MUL_AA: begin
        mul_a = {8'd0, a_sel};
        mul_b = {8'd0, a_sel};
      end
      gsc_pkg::OP_MUL_AR: begin
        mul_a = prod_r[15:0];
        mul_b = r2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared compare and subtract: one quotient or root bit per cycle
  always_comb begin
    if (ctl.op == gsc_pkg::OP_DIV_STEP) begin
      cand  = {rem_r[17:0], sh_r[31]};
      trial = {3'd0, s_r};
    end else begin
      cand  = {rem_r[16:0], sh_r[31:30]};
      trial = {res_r[16:0], 2'b01};
    end
    ge   = (cand >= trial);
    diff = cand - trial;
  end

  assign clamp = (s_r > r2_r);

  assign q16        = res_r[15:0];
  assign q16_signed = s_sel ? (16'd0 - q16) : q16;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      gsc_pkg::OP_NONE: begin
      end
      gsc_pkg::OP_LOAD: begin
        ax_r <= dz_x;
        ay_r <= dz_y;
        sx_r <= raw_x[7];
        sy_r <= raw_y[7];
      end
      gsc_pkg::OP_MUL_XX: prod_r <= mul_p;
      gsc_pkg::OP_MUL_YY: s_r    <= prod_r[15:0] + mul_p[15:0];
      gsc_pkg::OP_MUL_RR: r2_r   <= mul_p[15:0];
      gsc_pkg::OP_MUL_AA: prod_r <= mul_p;
      gsc_pkg::OP_MUL_AR: prod_r <= mul_p;
      gsc_pkg::OP_DIV_INIT: begin
        // upper dividend bits are below the divisor since the quotient fits 32 bits
        rem_r <= {3'd0, prod_r[31:16]};
        sh_r  <= {prod_r[15:0], 16'd0};
        res_r <= '0;
      end
      gsc_pkg::OP_DIV_STEP: begin
        rem_r <= ge ? diff : cand;
        sh_r  <= {sh_r[30:0], 1'b0};
        res_r <= {res_r[30:0], ge};
      end
      gsc_pkg::OP_SQRT_INIT_S: begin
        rem_r <= '0;
        sh_r  <= {s_r, 16'd0};
        res_r <= '0;
      end
      gsc_pkg::OP_SQRT_INIT_Q: begin
        rem_r <= '0;
        sh_r  <= res_r;
        res_r <= '0;
      end
      gsc_pkg::OP_SQRT_STEP: begin
        rem_r <= ge ? diff : cand;
        sh_r  <= {sh_r[29:0], 2'b00};
        res_r <= {res_r[30:0], ge};
      end
      gsc_pkg::OP_STORE_AX: begin
        if (ctl.axis) begin
          oy_r <= q16_signed;
        end else begin
          ox_r <= q16_signed;
        end
      end
      gsc_pkg::OP_STORE_UNCLAMP: begin
        ox_r  <= sx_r ? (16'd0 - {ax_r, 8'd0}) : {ax_r, 8'd0};
        oy_r  <= sy_r ? (16'd0 - {ay_r, 8'd0}) : {ay_r, 8'd0};
        mag_r <= q16;
      end
      gsc_pkg::OP_STORE_CLAMP_MAG: mag_r <= {cfg.max_radius, 8'd0};
      default: begin
      end
    endcase
  end

  assign axis_x    = ox_r;
  assign axis_y    = oy_r;
  assign magnitude = mag_r;

endmodule

/* src/gsc_ctrl.sv */
// sequencer that steps the shared units through one sample
module gsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          connected,
  input  logic          clamp,
  input  logic          out_free,
  output logic          busy,
  output logic          done,
  output gsc_pkg::ctl_t ctl
);

  gsc_pkg::state_t state_r, state_nxt;
  logic [gsc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic axis_r, axis_nxt;
  logic fin_r, fin_nxt;  // result ready, waiting for the output register

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gsc_pkg::ST_IDLE: begin
        if (start && connected) begin
          state_nxt = gsc_pkg::ST_SQX;
        end
      end
      gsc_pkg::ST_SQX:          state_nxt = gsc_pkg::ST_SQY;
      gsc_pkg::ST_SQY:          state_nxt = gsc_pkg::ST_SQR;
      gsc_pkg::ST_SQR:          state_nxt = gsc_pkg::ST_CMP;
      gsc_pkg::ST_CMP:
        state_nxt = clamp ? gsc_pkg::ST_CLAMP_MAG : gsc_pkg::ST_MAG_INIT;
      gsc_pkg::ST_MAG_INIT:     state_nxt = gsc_pkg::ST_MAG_RUN;
      gsc_pkg::ST_MAG_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = gsc_pkg::ST_STORE_U;
        end
      end
      gsc_pkg::ST_STORE_U:      state_nxt = gsc_pkg::ST_IDLE;
      gsc_pkg::ST_CLAMP_MAG:    state_nxt = gsc_pkg::ST_AX_SQ;
      gsc_pkg::ST_AX_SQ:        state_nxt = gsc_pkg::ST_AX_MUL;
      gsc_pkg::ST_AX_MUL:       state_nxt = gsc_pkg::ST_AX_DIV_INIT;
      gsc_pkg::ST_AX_DIV_INIT:  state_nxt = gsc_pkg::ST_AX_DIV;
      gsc_pkg::ST_AX_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = gsc_pkg::ST_AX_SQRT_INIT;
        end
      end
      gsc_pkg::ST_AX_SQRT_INIT: state_nxt = gsc_pkg::ST_AX_SQRT;
      gsc_pkg::ST_AX_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = gsc_pkg::ST_AX_STORE;
        end
      end
      gsc_pkg::ST_AX_STORE:
        state_nxt = axis_r ? gsc_pkg::ST_IDLE : gsc_pkg::ST_AX_SQ;
      default:                  state_nxt = gsc_pkg::ST_IDLE;
    endcase
  end

  // counter, axis select and finish flag
  always_comb begin
    cnt_nxt  = cnt_r;
    axis_nxt = axis_r;
    fin_nxt  = fin_r;
    if (done) begin
      fin_nxt = 1'b0;
    end
    unique case (state_r)
      gsc_pkg::ST_IDLE: begin
        if (start && !connected) begin
          fin_nxt = 1'b1;
        end
      end
      gsc_pkg::ST_MAG_INIT, gsc_pkg::ST_AX_SQRT_INIT: cnt_nxt = gsc_pkg::SQRT_LAST;
      gsc_pkg::ST_AX_DIV_INIT:                        cnt_nxt = gsc_pkg::DIV_LAST;
      gsc_pkg::ST_MAG_RUN, gsc_pkg::ST_AX_DIV, gsc_pkg::ST_AX_SQRT:
        cnt_nxt = cnt_r - 1'b1;
      gsc_pkg::ST_CLAMP_MAG:                          axis_nxt = 1'b0;
      gsc_pkg::ST_STORE_U:                            fin_nxt = 1'b1;
      gsc_pkg::ST_AX_STORE: begin
        axis_nxt = 1'b1;
        if (axis_r) begin
          fin_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctl.axis = axis_r;
    unique case (state_r)
      gsc_pkg::ST_IDLE:         ctl.op = start ? gsc_pkg::OP_LOAD : gsc_pkg::OP_NONE;
      gsc_pkg::ST_SQX:          ctl.op = gsc_pkg::OP_MUL_XX;
      gsc_pkg::ST_SQY:          ctl.op = gsc_pkg::OP_MUL_YY;
      gsc_pkg::ST_SQR:          ctl.op = gsc_pkg::OP_MUL_RR;
      gsc_pkg::ST_CMP:          ctl.op = gsc_pkg::OP_NONE;
      gsc_pkg::ST_MAG_INIT:     ctl.op = gsc_pkg::OP_SQRT_INIT_S;
      gsc_pkg::ST_MAG_RUN:      ctl.op = gsc_pkg::OP_SQRT_STEP;
      gsc_pkg::ST_STORE_U:      ctl.op = gsc_pkg::OP_STORE_UNCLAMP;
      gsc_pkg::ST_CLAMP_MAG:    ctl.op = gsc_pkg::OP_STORE_CLAMP_MAG;
      gsc_pkg::ST_AX_SQ:        ctl.op = gsc_pkg::OP_MUL_AA;
      gsc_pkg::ST_AX_MUL:       ctl.op = gsc_pkg::OP_MUL_AR;
      gsc_pkg::ST_AX_DIV_INIT:  ctl.op = gsc_pkg::OP_DIV_INIT;
      gsc_pkg::ST_AX_DIV:       ctl.op = gsc_pkg::OP_DIV_STEP;
      gsc_pkg::ST_AX_SQRT_INIT: ctl.op = gsc_pkg::OP_SQRT_INIT_Q;
      gsc_pkg::ST_AX_SQRT:      ctl.op = gsc_pkg::OP_SQRT_STEP;
      gsc_pkg::ST_AX_STORE:     ctl.op = gsc_pkg::OP_STORE_AX;
      default:                  ctl.op = gsc_pkg::OP_NONE;
    endcase
  end

  // a finished result waits here until the output register can take it
  assign done = fin_r && out_free;
  assign busy = (state_r != gsc_pkg::ST_IDLE) || fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsc_pkg::ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

/* src/gamepad_stick_conditioner.sv */
// top level of the gamepad stick conditioner
//
// one controller sample enters on the in_ channel (valid/stall); one conditioned
// result leaves on the out_ channel (valid/stall). in_stall is high while a sample
// is being worked on or its result waits; the sample is taken at an edge with
// in_valid high and in_stall low.
// a vector beyond max_radius is rescaled. the rescale path runs, per axis, a
// 32-step restoring divide and a 16-step square root, one bit per cycle through
// the single shift-subtract unit; the unclamped path runs one 16-step square
// root. one sample at a time: with the output register free, in_stall falls in
// the same cycle as out_valid rises, so the next sample can be taken in that
// cycle. the output register holds a finished result while out_stall is high;
// the next sample is already accepted and worked on meanwhile, and a second
// finished result waits inside until the register frees up. cfg_ registers
// (valid/ready, always ready) are to be written only while idle; the user is
// bound by this, and the block itself does not enforce it. synchronous reset
// (rst_n low) clears the held button word, empties the output register and
// loads threshold 8, offset 6, radius 64.
module gamepad_stick_conditioner (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_connected,
  input  logic signed [gsc_pkg::AXIS_W-1:0]    in_stick_x,
  input  logic signed [gsc_pkg::AXIS_W-1:0]    in_stick_y,
  input  logic        [gsc_pkg::BTN_W-1:0]     in_buttons,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [gsc_pkg::BTN_W-1:0]     out_held,
  output logic        [gsc_pkg::BTN_W-1:0]     out_pressed,
  output logic signed [gsc_pkg::OUT_W-1:0]     out_axis_x,
  output logic signed [gsc_pkg::OUT_W-1:0]     out_axis_y,
  output logic        [gsc_pkg::OUT_W-1:0]     out_magnitude,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [1:0]                    cfg_index,
  input  logic        [7:0]                    cfg_data
);

  gsc_pkg::cfg_t cfg_r;
  gsc_pkg::ctl_t ctl;

  logic [gsc_pkg::BTN_W-1:0] held_btn_r;
  logic [gsc_pkg::BTN_W-1:0] p_held_r, p_pressed_r;
  logic                      p_conn_r;
  logic                      out_valid_r;
  logic [gsc_pkg::BTN_W-1:0] o_held_r, o_pressed_r;
  logic [gsc_pkg::OUT_W-1:0] o_x_r, o_y_r, o_mag_r;

  logic start, busy, done, clamp, out_free;
  logic signed [gsc_pkg::OUT_W-1:0] dp_x, dp_y;
  logic        [gsc_pkg::OUT_W-1:0] dp_mag;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign out_free  = !out_valid_r || !out_stall;

  gsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .connected (in_connected),
    .clamp     (clamp),
    .out_free  (out_free),
    .busy      (busy),
    .done      (done),
    .ctl       (ctl)
  );

  gsc_datapath u_dp (
    .clk       (clk),
    .ctl       (ctl),
    .cfg       (cfg_r),
    .raw_x     (in_stick_x),
    .raw_y     (in_stick_y),
    .clamp     (clamp),
    .axis_x    (dp_x),
    .axis_y    (dp_y),
    .magnitude (dp_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_threshold <= 7'd8;
      cfg_r.dead_offset    <= 7'd6;
      cfg_r.max_radius     <= 8'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gsc_pkg::CFG_DEAD_THRESHOLD: cfg_r.dead_threshold <= cfg_data[6:0];
        gsc_pkg::CFG_DEAD_OFFSET:    cfg_r.dead_offset    <= cfg_data[6:0];
        gsc_pkg::CFG_MAX_RADIUS:     cfg_r.max_radius     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // button word is settled at the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_btn_r <= '0;
    end else if (start) begin
      held_btn_r <= in_connected ? in_buttons : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_conn_r    <= in_connected;
      p_held_r    <= in_buttons;
      p_pressed_r <= in_buttons & ~held_btn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      o_held_r    <= p_conn_r ? p_held_r    : '0;
      o_pressed_r <= p_conn_r ? p_pressed_r : '0;
      o_x_r       <= p_conn_r ? dp_x        : '0;
      o_y_r       <= p_conn_r ? dp_y        : '0;
      o_mag_r     <= p_conn_r ? dp_mag      : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_held      = o_held_r;
  assign out_pressed   = o_pressed_r;
  assign out_axis_x    = o_x_r;
  assign out_axis_y    = o_y_r;
  assign out_magnitude = o_mag_r;

endmodule
